// File: rtl/gasu_pkg.sv
// ----------------------------------------------------------------------------
// gasu_pkg
// Shared constants and types for the grid automaton generation step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gasu_pkg;

	localparam int SIDE   = 8;
	localparam int CELLS  = SIDE * SIDE;
	localparam int GRID_W = 64;

	typedef enum logic {
		KIND_LOAD    = 1'b0,
		KIND_ADVANCE = 1'b1
	} kind_t;

	typedef struct packed {
		logic en;
		logic load;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/grid_automaton_generation_step_unit.sv
// ----------------------------------------------------------------------------
// grid_automaton_generation_step_unit
// Bounded B12/S12 life-like automaton on an 8x8 grid, one cell per register.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): kind selects load of grid_word or one
// generation step; only the low SIDE*SIDE bits of grid_word are used.
// Output channel (out_valid/out_ready): grid_out is the packed grid after the
// item, first cell in the most significant bit, upper bits zero.
// Every item gives exactly one result, written to the output register, or to
// the skid register while a result waits. Throughput is one item per cycle
// while in_ready is high: all cells update in parallel from their registered neighbours.
// Results sit in an output register backed by one skid register; the unit
// keeps accepting items while one result waits, and drops in_ready only
// when both hold a result the receiver has not taken.
// Reset clears all cells to dead and empties both result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_automaton_generation_step_unit
	import gasu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [GRID_W-1:0] grid_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [GRID_W-1:0] grid_out
);

	cell_ctrl_t        ctrl;
	logic [CELLS-1:0]  next_grid;
	logic [GRID_W-1:0] new_res;
	logic              push;
	logic              pop;

	logic [GRID_W-1:0] out_q;
	logic              out_valid_q;
	logic [GRID_W-1:0] skid_q;
	logic              skid_valid_q;

	assign in_ready  = !skid_valid_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid_q && out_ready;
	assign ctrl.en   = push;
	assign ctrl.load = (kind_t'(kind) == KIND_LOAD);

	gasu_array u_array (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.load_grid (grid_word[CELLS-1:0]),
		.next_grid (next_grid)
	);

	assign new_res = GRID_W'(next_grid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else if (!push) begin
					out_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_valid_q) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= new_res;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_q <= new_res;
			end else begin
				skid_q <= new_res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign grid_out  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item while output register is empty");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid_q)
		else $error("accepted item produced no pending result");

	a_load_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !kind && !out_valid_q) |=>
			(out_q == GRID_W'($past(grid_word[CELLS-1:0]))))
		else $error("loaded grid not returned");

endmodule

`default_nettype wire

// File: rtl/gasu_cell.sv
// ----------------------------------------------------------------------------
// gasu_cell
// One grid cell: holds its state, counts live neighbours, applies B12/S12.
// ----------------------------------------------------------------------------
`default_nettype none

module gasu_cell
	import gasu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       load_bit,
	input  logic [7:0] nbr,
	output logic       state,
	output logic       next_state
);

	logic       state_q;
	logic [3:0] live;

	assign live = 4'($countones(nbr));

	always_comb begin
		if (ctrl.load) begin
			next_state = load_bit;
		end else begin
			next_state = (live == 4'd1) || (live == 4'd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= 1'b0;
		end else if (ctrl.en) begin
			state_q <= next_state;
		end
	end

	assign state = state_q;

endmodule

`default_nettype wire

// File: rtl/gasu_array.sv
// ----------------------------------------------------------------------------
// gasu_array
// SIDE by SIDE mesh of cells wired to their eight neighbours, dead past edges.
// ----------------------------------------------------------------------------
`default_nettype none

module gasu_array
	import gasu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [CELLS-1:0] load_grid,
	output logic [CELLS-1:0] next_grid
);

	logic [CELLS-1:0] cur_grid;

	for (genvar r = 0; r < SIDE; r++) begin : g_row
		for (genvar c = 0; c < SIDE; c++) begin : g_col
			localparam int POS = CELLS - 1 - (r * SIDE + c);
			logic [7:0] nbr;

			for (genvar k = 0; k < 9; k++) begin : g_nbr
				localparam int RR = r + k / 3 - 1;
				localparam int CC = c + k % 3 - 1;
				localparam int IX = (k < 4) ? k : k - 1;
				if (k != 4) begin : g_tap
					if (RR >= 0 && RR < SIDE && CC >= 0 && CC < SIDE) begin : g_in
						assign nbr[IX] = cur_grid[CELLS - 1 - (RR * SIDE + CC)];
					end else begin : g_edge
						assign nbr[IX] = 1'b0;
					end
				end
			end

			gasu_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.load_bit   (load_grid[POS]),
				.nbr        (nbr),
				.state      (cur_grid[POS]),
				.next_state (next_grid[POS])
			);
		end
	end

endmodule

`default_nettype wire

// File: verif/grid_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_step_checker
// Watches both channels of the grid automaton unit. Every accepted input item
// updates a local copy of the grid (load or one B12/S12 generation) and queues
// the packed grid it should return. Every accepted result is compared with
// the oldest queued grid. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------

module grid_step_checker
	import gasu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              kind,
	input  logic [GRID_W-1:0] grid_word,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [GRID_W-1:0] grid_out,
	output int                fail_count,
	output int                outstanding
);

	localparam logic [GRID_W-1:0] GRID_MASK = {GRID_W{1'b1}} >> (GRID_W - CELLS);

	logic [GRID_W-1:0] model_grid;
	logic [GRID_W-1:0] expected_grids[$];

	function automatic logic [GRID_W-1:0] next_generation(input logic [GRID_W-1:0] g);
		logic [GRID_W-1:0] nxt;
		int live;
		int rr;
		int cc;
		nxt = '0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				live = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						// cells past the edge are dead, no wrap
						if ((dr != 0 || dc != 0) && rr >= 0 && rr < SIDE && cc >= 0 && cc < SIDE)
							live += g[CELLS-1-(rr*SIDE+cc)];
					end
				end
				if (live == 1 || live == 2)
					nxt[CELLS-1-(r*SIDE+c)] = 1'b1;
			end
		end
		return nxt & GRID_MASK;
	endfunction

	task automatic report_mismatch(input string what, input logic [GRID_W-1:0] got,
			input logic [GRID_W-1:0] exp_grid);
		if (fail_count < 20)
			$display("%0t mismatch: %s got %h exp %h", $realtime, what, got, exp_grid);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_grid = '0;
			expected_grids.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_grids.size() == 0)
					report_mismatch("unexpected item, grid_out", grid_out, '0);
				else if (grid_out !== expected_grids[0]) begin
					report_mismatch("grid_out", grid_out, expected_grids[0]);
					void'(expected_grids.pop_front());
				end else
					void'(expected_grids.pop_front());
			end
			if (in_valid && in_ready) begin
				if (kind_t'(kind) == KIND_LOAD)
					model_grid = grid_word & GRID_MASK;
				else
					model_grid = next_generation(model_grid);
				expected_grids = {expected_grids, model_grid};
			end
			outstanding <= expected_grids.size();
		end
	end

endmodule

// File: verif/tb_grid_automaton_generation_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_automaton_generation_step_unit
// Drives load and generation items into the grid automaton unit with random
// gaps on both sides, long receiver hold-offs and drain pauses. Directed grids
// cover corners, edges, full and empty boards; random sequences load a grid of
// varying density and run several generations. A checker predicts results.
// ----------------------------------------------------------------------------

module tb_grid_automaton_generation_step_unit;
	import gasu_pkg::*;

	localparam int TOTAL_ITEMS = 1370;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 40;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic              kind      = KIND_LOAD;
	logic [GRID_W-1:0] grid_word = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [GRID_W-1:0] grid_out;

	int fail_count;
	int outstanding;
	int sent      = 0;
	bit no_idle   = 1'b0;
	bit hold_req  = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	grid_automaton_generation_step_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.grid_word (grid_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.grid_out  (grid_out)
	);

	grid_step_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.grid_word   (grid_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.grid_out    (grid_out),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	function automatic logic [GRID_W-1:0] rand_word();
		logic [GRID_W-1:0] a;
		logic [GRID_W-1:0] b;
		logic [GRID_W-1:0] c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return a;
			1: return a & b;
			2: return a & b & c;
			default: return a | b;
		endcase
	endfunction

	task automatic send_item(input logic k, input logic [GRID_W-1:0] w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		grid_word <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// receiver: random back-pressure, long hold-off on request
	initial begin : receiver
		int wait_cycles;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				wait_cycles = HOLD_CYCLES;
				hold_req = 1'b0;
			end else
				wait_cycles = no_idle ? 0 : $urandom_range(0, 4);
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** grid_automaton_generation_step_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int steps;
		int next_hold;
		bit paused;
		next_hold = 400;
		paused    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty board after reset, extremes, corners, edges
		send_item(KIND_ADVANCE, '1);
		send_item(KIND_LOAD, '0);
		send_item(KIND_ADVANCE, '0);
		send_item(KIND_LOAD, '1);
		send_item(KIND_ADVANCE, '0);
		send_item(KIND_LOAD, 64'h8000_0000_0000_0000);
		send_item(KIND_ADVANCE, '1);
		send_item(KIND_ADVANCE, '0);
		send_item(KIND_LOAD, 64'h0000_0000_0000_0001);
		send_item(KIND_ADVANCE, 64'hFFFF_0000_FFFF_0000);
		send_item(KIND_ADVANCE, '0);
		send_item(KIND_LOAD, 64'h0000_0010_0000_0000);
		send_item(KIND_ADVANCE, '0);
		send_item(KIND_ADVANCE, '0);
		send_item(KIND_LOAD, 64'hAA55_AA55_AA55_AA55);
		send_item(KIND_ADVANCE, '0);
		send_item(KIND_LOAD, 64'h8100_0000_0000_0081);
		send_item(KIND_ADVANCE, '0);
		send_item(KIND_LOAD, 64'hFF81_8181_8181_81FF);
		send_item(KIND_ADVANCE, '0);
		send_item(KIND_LOAD, 64'h5555_5555_5555_5555);
		send_item(KIND_ADVANCE, 64'h5555_5555_5555_5555);
		wait_for_drain();

		while (sent < TOTAL_ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if (sent >= next_hold) begin
				hold_req  = 1'b1;
				next_hold = next_hold + 600;
			end
			if (!paused && sent >= 800) begin
				wait_for_drain();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) == 0)
				send_item(KIND_ADVANCE, rand_word());
			else begin
				send_item(KIND_LOAD, rand_word());
				steps = $urandom_range(0, 8);
				repeat (steps) send_item(KIND_ADVANCE, rand_word());
			end
		end

		no_idle = 1'b0;
		wait_for_drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("** grid_automaton_generation_step_unit: PASSED **");
		else
			$display("** grid_automaton_generation_step_unit: FAILED **");
		$finish;
	end

endmodule
